@@ rtl/ctr_pkg.sv @@
`default_nettype none

package ctr_pkg;

    localparam int NAME_COUNT    = 147;
    localparam int MAX_NAME_LEN  = 20;
    localparam int TABLE_NAMES   = 147;
    localparam int TABLE_MAX_LEN = 20;
    localparam int NAME_BITS     = 8 * TABLE_MAX_LEN;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_HEX3  = 2'd1;
    localparam logic [1:0] KIND_HEX6  = 2'd2;
    localparam logic [1:0] KIND_NAMED = 2'd3;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_hash;
        logic       is_stop;
        logic       is_comma;
        logic       is_hex;
        logic       last;
    } ctr_tok_t;

    // name text, right aligned as a string literal
    function automatic logic [NAME_BITS-1:0] name_str(input int idx);
        logic [NAME_BITS-1:0] s;
        s = '0;
        case (idx)
            0: s = "aliceblue";          1: s = "antiquewhite";
            2: s = "aqua";               3: s = "aquamarine";
            4: s = "azure";              5: s = "beige";
            6: s = "bisque";             7: s = "black";
            8: s = "blanchedalmond";     9: s = "blue";
            10: s = "blueviolet";        11: s = "brown";
            12: s = "burlywood";         13: s = "cadetblue";
            14: s = "chartreuse";        15: s = "chocolate";
            16: s = "coral";             17: s = "cornflowerblue";
            18: s = "cornsilk";          19: s = "crimson";
            20: s = "cyan";              21: s = "darkblue";
            22: s = "darkcyan";          23: s = "darkgoldenrod";
            24: s = "darkgray";          25: s = "darkgreen";
            26: s = "darkgrey";          27: s = "darkkhaki";
            28: s = "darkmagenta";       29: s = "darkolivegreen";
            30: s = "darkorange";        31: s = "darkorchid";
            32: s = "darkred";           33: s = "darksalmon";
            34: s = "darkseagreen";      35: s = "darkslateblue";
            36: s = "darkslategray";     37: s = "darkslategrey";
            38: s = "darkturquoise";     39: s = "darkviolet";
            40: s = "deeppink";          41: s = "deepskyblue";
            42: s = "dimgray";           43: s = "dimgrey";
            44: s = "dodgerblue";        45: s = "firebrick";
            46: s = "floralwhite";       47: s = "forestgreen";
            48: s = "fuchsia";           49: s = "gainsboro";
            50: s = "ghostwhite";        51: s = "gold";
            52: s = "goldenrod";         53: s = "gray";
            54: s = "green";             55: s = "greenyellow";
            56: s = "grey";              57: s = "honeydew";
            58: s = "hotpink";           59: s = "indianred";
            60: s = "indigo";            61: s = "ivory";
            62: s = "khaki";             63: s = "lavender";
            64: s = "lavenderblush";     65: s = "lawngreen";
            66: s = "lemonchiffon";      67: s = "lightblue";
            68: s = "lightcoral";        69: s = "lightcyan";
            70: s = "lightgoldenrodyellow"; 71: s = "lightgray";
            72: s = "lightgreen";        73: s = "lightgrey";
            74: s = "lightpink";         75: s = "lightsalmon";
            76: s = "lightseagreen";     77: s = "lightskyblue";
            78: s = "lightslategray";    79: s = "lightslategrey";
            80: s = "lightsteelblue";    81: s = "lightyellow";
            82: s = "lime";              83: s = "limegreen";
            84: s = "linen";             85: s = "magenta";
            86: s = "maroon";            87: s = "mediumaquamarine";
            88: s = "mediumblue";        89: s = "mediumorchid";
            90: s = "mediumpurple";      91: s = "mediumseagreen";
            92: s = "mediumslateblue";   93: s = "mediumspringgreen";
            94: s = "mediumturquoise";   95: s = "mediumvioletred";
            96: s = "midnightblue";      97: s = "mintcream";
            98: s = "mistyrose";         99: s = "moccasin";
            100: s = "navajowhite";      101: s = "navy";
            102: s = "oldlace";          103: s = "olive";
            104: s = "olivedrab";        105: s = "orange";
            106: s = "orangered";        107: s = "orchid";
            108: s = "palegoldenrod";    109: s = "palegreen";
            110: s = "paleturquoise";    111: s = "palevioletred";
            112: s = "papayawhip";       113: s = "peachpuff";
            114: s = "peru";             115: s = "pink";
            116: s = "plum";             117: s = "powderblue";
            118: s = "purple";           119: s = "red";
            120: s = "rosybrown";        121: s = "royalblue";
            122: s = "saddlebrown";      123: s = "salmon";
            124: s = "sandybrown";       125: s = "seagreen";
            126: s = "seashell";         127: s = "sienna";
            128: s = "silver";           129: s = "skyblue";
            130: s = "slateblue";        131: s = "slategray";
            132: s = "slategrey";        133: s = "snow";
            134: s = "springgreen";      135: s = "steelblue";
            136: s = "tan";              137: s = "teal";
            138: s = "thistle";          139: s = "tomato";
            140: s = "turquoise";        141: s = "violet";
            142: s = "wheat";            143: s = "white";
            144: s = "whitesmoke";       145: s = "yellow";
            146: s = "yellowgreen";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic int name_len(input int idx);
        logic [NAME_BITS-1:0] s;
        int n;
        s = name_str(idx);
        n = 0;
        for (int k = 0; k < TABLE_MAX_LEN; k++)
        begin
            if (s[k*8 +: 8] != 8'h00)
            begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    // name text with the first character in the lowest byte
    function automatic logic [NAME_BITS-1:0] name_fwd(input int idx);
        logic [NAME_BITS-1:0] s;
        logic [NAME_BITS-1:0] r;
        int n;
        s = name_str(idx);
        n = name_len(idx);
        r = '0;
        for (int k = 0; k < TABLE_MAX_LEN; k++)
        begin
            if (k < n)
            begin
                r[k*8 +: 8] = s[(n-1-k)*8 +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] name_byte(input logic [NAME_BITS-1:0] r,
                                             input logic [4:0] p);
        logic [7:0] b;
        b = 8'h00;
        for (int k = 0; k < TABLE_MAX_LEN; k++)
        begin
            if (p == 5'(k))
            begin
                b = r[k*8 +: 8];
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ctr_if.sv @@
`default_nettype none

interface ctr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ctr_out_if;
    logic       valid;
    logic       ready;
    logic       is_color;
    logic [1:0] first_kind;
    logic       has_second;

    modport source (output valid, output is_color, output first_kind, output has_second,
                    input ready);
    modport sink (input valid, input is_color, input first_kind, input has_second,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/ctr_front.sv @@
`default_nettype none

module ctr_front
    import ctr_pkg::*;
(
    input  wire logic [7:0] text_byte,
    input  wire logic       last_byte,
    output ctr_tok_t        tok
);

    always_comb
    begin
        tok.char_code = text_byte;
        tok.last      = last_byte;
        tok.is_hash   = (text_byte == CH_HASH);
        tok.is_comma  = (text_byte == CH_COMMA);
        tok.is_stop   = (text_byte == CH_SPACE) || (text_byte == CH_LF) ||
                        (text_byte == CH_NUL) || (text_byte == CH_COMMA);
        tok.is_hex    = (text_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    end

endmodule

`default_nettype wire

@@ rtl/ctr_queue.sv @@
`default_nettype none

module ctr_queue
    import ctr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  ctr_tok_t  push_tok,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output ctr_tok_t  head_tok
);

    ctr_tok_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_tok = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue pop lost");

endmodule

`default_nettype wire

@@ rtl/ctr_back.sv @@
`default_nettype none

module ctr_back
    import ctr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic tok_valid,
    input  ctr_tok_t  tok,
    output logic      tok_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [3:0] out_bits
);

    typedef enum logic [1:0] {
        PH_HASH1,
        PH_BODY1,
        PH_HASH2,
        PH_BODY2
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  done_reg, done_next;
    logic [3:0]            bits_reg, bits_next;
    logic [4:0]            pos_reg, pos_next;
    logic [2:0]            hex_reg, hex_next;
    logic [NAME_COUNT-1:0] alive_reg, alive_next;
    logic                  term_reg, term_next;
    logic                  ovalid_reg;
    logic [3:0]            obits_reg;

    logic [NAME_COUNT-1:0] feed_alive;
    logic [NAME_COUNT-1:0] len_hit;
    logic [4:0]            pos_feed;
    logic [2:0]            hex_feed;
    logic [1:0]            kind_cur;
    logic [1:0]            kind_new;
    logic [3:0]            bits_fin;
    logic                  consume;

    // per-name match against the byte at the current position
    for (genvar gi = 0; gi < NAME_COUNT; gi++)
    begin : g_name
        if (gi < TABLE_NAMES)
        begin : g_real
            localparam logic [NAME_BITS-1:0] NM = name_fwd(gi);
            localparam int                   LEN = name_len(gi);
            assign feed_alive[gi] = alive_reg[gi] && (pos_reg < 5'(MAX_NAME_LEN)) &&
                                    (pos_reg < 5'(TABLE_MAX_LEN)) &&
                                    (name_byte(NM, pos_reg) == tok.char_code);
            assign len_hit[gi] = (pos_next == 5'(LEN));
        end
        else
        begin : g_spare
            assign feed_alive[gi] = 1'b0;
            assign len_hit[gi]    = 1'b0;
        end
    end

    function automatic logic [1:0] kind_of(input logic [4:0] p, input logic [2:0] h,
                                           input logic t);
        logic [1:0] k;
        if (({2'b00, h} == p) && (p == 5'd3))
        begin
            k = KIND_HEX3;
        end
        else if (({2'b00, h} == p) && (p == 5'd6))
        begin
            k = KIND_HEX6;
        end
        else if (t)
        begin
            k = KIND_NAMED;
        end
        else
        begin
            k = KIND_NONE;
        end
        return k;
    endfunction

    assign pos_feed = (pos_reg == 5'd31) ? pos_reg : pos_reg + 5'd1;
    assign hex_feed = (({2'b00, hex_reg} == pos_reg) && (pos_reg < 5'd7) && tok.is_hex) ?
                      hex_reg + 3'd1 : hex_reg;
    assign kind_cur = kind_of(pos_reg, hex_reg, term_reg);
    assign consume  = tok_valid && (!tok.last || !ovalid_reg || out_ready);
    assign tok_pop  = consume;

    always_comb
    begin
        logic startb;
        phase_next = phase_reg;
        done_next  = done_reg;
        bits_next  = bits_reg;
        pos_next   = pos_reg;
        hex_next   = hex_reg;
        alive_next = alive_reg;
        startb     = 1'b0;
        if (!done_reg)
        begin
            case (phase_reg)
                PH_HASH1, PH_HASH2:
                begin
                    if (tok.is_hash)
                    begin
                        phase_next = (phase_reg == PH_HASH1) ? PH_BODY1 : PH_BODY2;
                        startb     = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        bits_next = 4'd0;
                    end
                end
                PH_BODY1:
                begin
                    if (tok.is_stop)
                    begin
                        if (kind_cur == KIND_NONE)
                        begin
                            done_next = 1'b1;
                            bits_next = 4'd0;
                        end
                        else if (tok.is_comma)
                        begin
                            bits_next  = {1'b0, kind_cur, 1'b0};
                            phase_next = PH_HASH2;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            bits_next = {1'b0, kind_cur, 1'b1};
                        end
                    end
                    else
                    begin
                        pos_next   = pos_feed;
                        hex_next   = hex_feed;
                        alive_next = feed_alive;
                    end
                end
                PH_BODY2:
                begin
                    if (tok.is_stop)
                    begin
                        done_next = 1'b1;
                        bits_next = (kind_cur != KIND_NONE) ?
                                    {1'b1, bits_reg[2:1], 1'b1} : 4'd0;
                    end
                    else
                    begin
                        pos_next   = pos_feed;
                        hex_next   = hex_feed;
                        alive_next = feed_alive;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                    bits_next = 4'd0;
                end
            endcase
        end
        if (startb)
        begin
            pos_next   = 5'd0;
            hex_next   = 3'd0;
            alive_next = '1;
        end
        term_next = |(alive_next & len_hit);
        kind_new  = kind_of(pos_next, hex_next, term_next);

        // verdict at the end of the text
        bits_fin = bits_next;
        if (!done_next)
        begin
            if (phase_next == PH_BODY1)
            begin
                bits_fin = (kind_new != KIND_NONE) ? {1'b0, kind_new, 1'b1} : 4'd0;
            end
            else if (phase_next == PH_BODY2)
            begin
                bits_fin = (kind_new != KIND_NONE) ? {1'b1, bits_next[2:1], 1'b1} : 4'd0;
            end
            else
            begin
                bits_fin = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HASH1;
            done_reg   <= 1'b0;
            bits_reg   <= 4'd0;
            pos_reg    <= 5'd0;
            hex_reg    <= 3'd0;
            alive_reg  <= '1;
            term_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            obits_reg  <= 4'd0;
        end
        else
        begin
            if (consume && tok.last)
            begin
                phase_reg  <= PH_HASH1;
                done_reg   <= 1'b0;
                bits_reg   <= 4'd0;
                pos_reg    <= 5'd0;
                hex_reg    <= 3'd0;
                alive_reg  <= '1;
                term_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
                obits_reg  <= bits_fin;
            end
            else
            begin
                if (consume)
                begin
                    phase_reg <= phase_next;
                    done_reg  <= done_next;
                    bits_reg  <= bits_next;
                    pos_reg   <= pos_next;
                    hex_reg   <= hex_next;
                    alive_reg <= alive_next;
                    term_reg  <= term_next;
                end
                if (out_ready)
                begin
                    ovalid_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_bits  = obits_reg;

    a_no_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !obits_reg[0]) |-> obits_reg[3:1] == 3'd0)
        else $error("fields set on a non-matching verdict");

    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (!done_reg && (phase_reg == PH_HASH2 || phase_reg == PH_BODY2)) |->
        (bits_reg[0] == 1'b0 && bits_reg[2:1] != KIND_NONE))
        else $error("second spec pending without a first kind");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && tok.last) |=> (phase_reg == PH_HASH1 && !done_reg && ovalid_reg))
        else $error("no restart after end of text");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok.last && ovalid_reg && !out_ready) |-> !consume)
        else $error("end byte consumed over a pending result");

endmodule

`default_nettype wire

@@ rtl/color_token_recognizer_top.sv @@
`default_nettype none

// color token recogniser
// in_ch carries one text byte per item with last_byte marking the final byte;
// out_ch carries one verdict item (is_color, first_kind, has_second) per text,
// produced for the final byte and for no other byte
// one byte is taken per cycle while the queue is not full: the front
// classifies the byte (hash, hex digit, stop byte, comma) and writes it to a
// four-item queue; the back runs the spec state machine and updates all name
// match flags in parallel, one byte per cycle unless a final byte waits on a
// pending verdict, so throughput is one item per cycle in steady flow
// with the queue empty the final byte passes through the queue register, then
// the back writes the verdict to the output register; a stall on out_ch holds
// it there; the back keeps consuming ordinary bytes and only waits on the next
// final byte, and the queue holds that final byte and three more before
// in_ch.ready drops; reset (rst_n low, asynchronous) empties the queue, drops
// any pending verdict and returns the recogniser to waiting for the first hash
module color_token_recognizer_top
    import ctr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ctr_in_if.sink    in_ch,
    ctr_out_if.source out_ch
);

    ctr_tok_t   front_tok;
    ctr_tok_t   head_tok;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic [3:0] verdict;

    ctr_front u_front (
        .text_byte (in_ch.text_byte),
        .last_byte (in_ch.last_byte),
        .tok       (front_tok)
    );

    // queue decouples intake from the matcher
    ctr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_ch.valid),
        .push_tok (front_tok),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_tok (head_tok)
    );

    assign in_ch.ready = !q_full;

    ctr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!q_empty),
        .tok       (head_tok),
        .tok_pop   (q_pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_bits  (verdict)
    );

    // verdict layout: bit0 match, bits 2:1 first form, bit3 second present
    assign out_ch.is_color   = verdict[0];
    assign out_ch.first_kind = verdict[2:1];
    assign out_ch.has_second = verdict[3];

endmodule

`default_nettype wire
